// ===== rtl/core/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

    // Working variables of the compression function.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1_vars_t;

    typedef logic [4:0][31:0] sha1_chain_t;

    // Entry 0 is the most significant digest word.
    localparam sha1_chain_t H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_GROUP1 = 7'd20;
    localparam logic [6:0] ROUND_GROUP2 = 7'd40;
    localparam logic [6:0] ROUND_GROUP3 = 7'd60;
    localparam logic [6:0] ROUND_LAST   = 7'd79;
    localparam logic [6:0] SCHED_LOADED = 7'd16;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/core/sha1_round.sv =====
`default_nettype none

module sha1_round (
    input  wire logic [6:0]          round_idx,
    input  wire sha1_pkg::sha1_vars_t cur,
    input  wire logic [31:0]         w,
    output sha1_pkg::sha1_vars_t     nxt
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] temp;

    always_comb
    begin
        if (round_idx < sha1_pkg::ROUND_GROUP1)
        begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = sha1_pkg::K_ROUND0;
        end
        else if (round_idx < sha1_pkg::ROUND_GROUP2)
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = sha1_pkg::K_ROUND1;
        end
        else if (round_idx < sha1_pkg::ROUND_GROUP3)
        begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = sha1_pkg::K_ROUND2;
        end
        else
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = sha1_pkg::K_ROUND3;
        end

        temp  = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
        nxt.a = temp;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_hasher.sv =====
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid/in_ready    msg_byte, byte_present, end_of_message
// output    out_valid/out_ready  digest_word, word_index, last_word
//
// A byte that does not complete a block leaves the input ready for the next item.
// A byte that completes a 64-byte block holds off the input while the block is compressed:
// 80 rounds through the one shared round unit, then a chain update.
// An end-of-message item adds the padding bytes, one or two such
// compressions, and then five digest words, each held until out_ready.
// Reset clears control state and loads H_INIT into the chaining words; the block store is not reset.

module sha1_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [2:0]            ret_reg, ret_next;
    logic [5:0]            fill_reg, fill_next;
    logic [31:0]           total_reg, total_next;
    logic                  marker_done_reg, marker_done_next;
    logic                  len_phase_reg, len_phase_next;
    logic [6:0]            round_reg, round_next;
    logic [2:0]            idx_reg, idx_next;
    sha1_pkg::sha1_chain_t h_reg, h_next;
    sha1_pkg::sha1_vars_t  vars_reg, vars_next;
    logic [511:0]          blk_reg, blk_next;

    sha1_pkg::sha1_vars_t  round_out;
    sha1_pkg::sha1_vars_t  chain_vars;
    logic                  in_fire;
    logic                  out_fire;
    logic [31:0]           win0;
    logic [31:0]           mix;
    logic [31:0]           w_t;
    logic [63:0]           len_bits;
    logic [5:0]            len_sh;
    logic [7:0]            len_byte;
    logic [7:0]            pad_byte;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign in_fire     = in_valid & in_ready;
    assign out_fire    = out_valid & out_ready;
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == sha1_pkg::WORD_LAST);

    // The block store doubles as the 16-word schedule window: word 0 sits at the top.
    assign win0 = blk_reg[511:480];
    assign mix  = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ win0;
    assign w_t  = (round_reg < sha1_pkg::SCHED_LOADED) ? win0 : {mix[30:0], mix[31]};

    assign len_bits = {29'd0, total_reg, 3'd0};
    assign len_sh   = {~fill_reg[2:0], 3'b000};
    assign len_byte = len_bits[len_sh +: 8];

    assign chain_vars.a = h_reg[0];
    assign chain_vars.b = h_reg[1];
    assign chain_vars.c = h_reg[2];
    assign chain_vars.d = h_reg[3];
    assign chain_vars.e = h_reg[4];

    sha1_round u_round (
        .round_idx (round_reg),
        .cur       (vars_reg),
        .w         (w_t),
        .nxt       (round_out)
    );

    always_comb
    begin
        if (!marker_done_reg)
        begin
            pad_byte = sha1_pkg::PAD_MARKER;
        end
        else if ((fill_reg >= sha1_pkg::LEN_POS) && len_phase_reg)
        begin
            pad_byte = len_byte;
        end
        else
        begin
            pad_byte = 8'd0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        fill_next        = fill_reg;
        total_next       = total_reg;
        marker_done_next = marker_done_reg;
        len_phase_next   = len_phase_reg;
        round_next       = round_reg;
        idx_next         = idx_reg;
        h_next           = h_reg;
        vars_next        = vars_reg;
        blk_next         = blk_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    marker_done_next = 1'b0;
                    len_phase_next   = 1'b0;
                    if (byte_present)
                    begin
                        blk_next   = {blk_reg[503:0], msg_byte};
                        fill_next  = fill_reg + 6'd1;
                        total_next = total_reg + 32'd1;
                    end
                    if (byte_present && (fill_reg == sha1_pkg::FILL_LAST))
                    begin
                        state_next = ST_COMP;
                        ret_next   = end_of_message ? ST_PAD : ST_IDLE;
                        vars_next  = chain_vars;
                        round_next = 7'd0;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                blk_next  = {blk_reg[503:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (!marker_done_reg)
                begin
                    marker_done_next = 1'b1;
                    // The length fits in this block when the marker lands before it.
                    if (fill_reg < sha1_pkg::LEN_POS)
                    begin
                        len_phase_next = 1'b1;
                    end
                end
                if (fill_reg == sha1_pkg::FILL_LAST)
                begin
                    state_next = ST_COMP;
                    ret_next   = len_phase_reg ? ST_OUT : ST_PAD;
                    vars_next  = chain_vars;
                    round_next = 7'd0;
                    if (!len_phase_reg)
                    begin
                        len_phase_next = 1'b1;
                    end
                end
            end
            ST_COMP:
            begin
                vars_next  = round_out;
                round_next = round_reg + 7'd1;
                blk_next   = {blk_reg[479:0], w_t};
                if (round_reg == sha1_pkg::ROUND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                h_next[0]  = h_reg[0] + vars_reg.a;
                h_next[1]  = h_reg[1] + vars_reg.b;
                h_next[2]  = h_reg[2] + vars_reg.c;
                h_next[3]  = h_reg[3] + vars_reg.d;
                h_next[4]  = h_reg[4] + vars_reg.e;
                state_next = ret_reg;
                idx_next   = 3'd0;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha1_pkg::WORD_LAST)
                    begin
                        h_next     = sha1_pkg::H_INIT;
                        fill_next  = 6'd0;
                        total_next = 32'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ret_reg         <= ST_IDLE;
            fill_reg        <= 6'd0;
            total_reg       <= 32'd0;
            marker_done_reg <= 1'b0;
            len_phase_reg   <= 1'b0;
            round_reg       <= 7'd0;
            idx_reg         <= 3'd0;
            h_reg           <= sha1_pkg::H_INIT;
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            fill_reg        <= fill_next;
            total_reg       <= total_next;
            marker_done_reg <= marker_done_next;
            len_phase_reg   <= len_phase_next;
            round_reg       <= round_next;
            idx_reg         <= idx_next;
            h_reg           <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
        blk_reg  <= blk_next;
    end

endmodule

`default_nettype wire

// ===== bench/sha1_hasher_tb.sv =====
`default_nettype none

module sha1_hasher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 310;
    localparam int DRAIN_CYCLES = 300;
    localparam int LONG_HOLD = 300;

    localparam logic [159:0] EMPTY_DIGEST =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] ABC_DIGEST =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         eom;
        logic         known;
        logic [159:0] digest;
    } step_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        is_last;
    } digest_word_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} rx_mode_t;

    // The digest column is only filled in where the value is a published vector.
    localparam step_t STEPS [15] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 160'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 160'd0},
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'd0},
        '{8'h5A, 1'b0, 1'b0, 1'b0, 160'd0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'd0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 160'd0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 160'd0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 160'd0},
        '{8'h7F, 1'b1, 1'b0, 1'b0, 160'd0},
        '{8'hA5, 1'b0, 1'b1, 1'b0, 160'd0},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 160'd0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  msg_byte = 8'd0;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // Model of the hashing state.
    sha1_pkg::sha1_chain_t hash_chain = sha1_pkg::H_INIT;
    logic [7:0]  block_bytes [64];
    logic [5:0]  fill_cnt = '0;
    logic [31:0] msg_len = '0;

    digest_word_t digest_q [$];
    int errors = 0;
    int words_taken = 0;
    int burst_left = 0;
    int items_sent = 0;

    sha1_hasher u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .msg_byte       (msg_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One 80-round compression of block_bytes into hash_chain.
    function automatic void compress_block();
        logic [31:0] sched [80];
        sha1_pkg::sha1_vars_t v;
        logic [31:0] f;
        logic [31:0] k;
        logic [31:0] t;
        int r;
        for (r = 0; r < 16; r++)
            sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                        block_bytes[4*r+2], block_bytes[4*r+3]};
        for (r = 16; r < 80; r++)
            sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
        v.a = hash_chain[0];
        v.b = hash_chain[1];
        v.c = hash_chain[2];
        v.d = hash_chain[3];
        v.e = hash_chain[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < int'(sha1_pkg::ROUND_GROUP1))
            begin
                f = (v.b & v.c) | (~v.b & v.d);
                k = sha1_pkg::K_ROUND0;
            end
            else if (r < int'(sha1_pkg::ROUND_GROUP2))
            begin
                f = v.b ^ v.c ^ v.d;
                k = sha1_pkg::K_ROUND1;
            end
            else if (r < int'(sha1_pkg::ROUND_GROUP3))
            begin
                f = (v.b & v.c) | (v.b & v.d) | (v.c & v.d);
                k = sha1_pkg::K_ROUND2;
            end
            else
            begin
                f = v.b ^ v.c ^ v.d;
                k = sha1_pkg::K_ROUND3;
            end
            t = rotl(v.a, 5) + f + v.e + k + sched[r];
            v.e = v.d;
            v.d = v.c;
            v.c = rotl(v.b, 30);
            v.b = v.a;
            v.a = t;
        end
        hash_chain[0] += v.a;
        hash_chain[1] += v.b;
        hash_chain[2] += v.c;
        hash_chain[3] += v.d;
        hash_chain[4] += v.e;
    endfunction

    // Applies one item to the model; returns 1 with the digest when a message closes.
    function automatic bit hash_item(input logic [7:0] data, input logic present,
                                     input logic eom, output sha1_pkg::sha1_chain_t digest);
        logic [63:0] bit_len;
        int i;
        digest = '0;
        if (present)
        begin
            block_bytes[fill_cnt] = data;
            msg_len++;
            if (fill_cnt == sha1_pkg::FILL_LAST)
                compress_block();
            fill_cnt++;
        end
        if (!eom)
            return 1'b0;
        block_bytes[fill_cnt] = sha1_pkg::PAD_MARKER;
        // No room for the length after the marker: pad out and spend an extra block.
        if (fill_cnt >= sha1_pkg::LEN_POS)
        begin
            for (i = int'(fill_cnt) + 1; i < 64; i++)
                block_bytes[i] = 8'h00;
            compress_block();
            for (i = 0; i < int'(sha1_pkg::LEN_POS); i++)
                block_bytes[i] = 8'h00;
        end
        else
        begin
            for (i = int'(fill_cnt) + 1; i < int'(sha1_pkg::LEN_POS); i++)
                block_bytes[i] = 8'h00;
        end
        bit_len = {29'd0, msg_len, 3'b000};
        for (i = 0; i < 8; i++)
            block_bytes[int'(sha1_pkg::LEN_POS) + i] = bit_len[8*(7-i) +: 8];
        compress_block();
        digest = hash_chain;
        hash_chain = sha1_pkg::H_INIT;
        fill_cnt = '0;
        msg_len = '0;
        return 1'b1;
    endfunction

    // Offers one item in the current burst and records what it should produce.
    task automatic send_item(input logic [7:0] data, input logic present, input logic eom,
                             input logic known, input logic [159:0] known_digest);
        int gap;
        int i;
        sha1_pkg::sha1_chain_t digest;
        digest_word_t w;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(20, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        msg_byte <= data;
        byte_present <= present;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (hash_item(data, present, eom, digest))
        begin
            for (i = 0; i < 5; i++)
            begin
                w.word = known ? known_digest[159 - 32*i -: 32] : digest[i];
                w.idx = 3'(i);
                w.is_last = (3'(i) == sha1_pkg::WORD_LAST);
                digest_q.push_back(w);
            end
        end
    endtask

    task automatic send_message(input int len);
        int i;
        logic merge_end;
        merge_end = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            send_item(8'($urandom_range(0, 255)), 1'b1, merge_end && (i == len - 1),
                      1'b0, '0);
        end
        if (!merge_end)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
    endtask

    initial
    begin : stimulus
        int len;
        int pick;
        int boundary [4];
        boundary = '{55, 56, 63, 64};
        foreach (block_bytes[i])
            block_bytes[i] = 8'h00;
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        foreach (STEPS[i])
            send_item(STEPS[i].data, STEPS[i].present, STEPS[i].eom,
                      STEPS[i].known, STEPS[i].digest);

        // Lengths where the padding just fits, just misses, or the data fills a block.
        items_sent = 0;
        foreach (boundary[i])
            send_message(boundary[i]);
        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(0, 8);
            else if (pick < 9)
                len = $urandom_range(9, 70);
            else
                len = $urandom_range(110, 130);
            // Keep the last message within the item budget.
            if (len > RANDOM_ITEMS - items_sent - 1)
                len = RANDOM_ITEMS - items_sent - 1;
            send_message(len);
        end
        in_valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : receiver
        rx_mode_t   mode;
        int         mode_left;
        int         hold_left;
        int         holds_done;
        logic [2:0] phase;
        logic [7:0] stall_mask;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        holds_done = 0;
        phase = '0;
        stall_mask = '0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            // Hold a pending digest long enough for the input side to back up.
            if (hold_left == 0 && out_valid &&
                ((holds_done == 0 && words_taken >= 7) ||
                 (holds_done == 1 && words_taken >= 40)))
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                    stall_mask = 8'($urandom_range(0, 255));
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= stall_mask[phase];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        digest_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_taken++;
            if (digest_q.size() == 0)
            begin
                errors++;
                $display("%0t: digest word %h index %0d last %0b with none expected",
                         $time, digest_word, word_index, last_word);
            end
            else
            begin
                want = digest_q.pop_front();
                if (digest_word !== want.word)
                begin
                    errors++;
                    $display("%0t: digest_word expected %h actual %h",
                             $time, want.word, digest_word);
                end
                if (word_index !== want.idx)
                begin
                    errors++;
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, want.idx, word_index);
                end
                if (last_word !== want.is_last)
                begin
                    errors++;
                    $display("%0t: last_word expected %0b actual %0b",
                             $time, want.is_last, last_word);
                end
            end
        end
    end

    initial
    begin : watchdog
        #10000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
